FILE: hw/rtl/uep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uep_pkg
// Shared types and constants for the unicode escape parser: the request and
// response beats, the classified character passed from front to back, and the
// status codes.
// ----------------------------------------------------------------------------
package uep_pkg;

   // Character codes the parser looks for
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_UPPER_U   = 8'h55;

   // Digit counts that close a hex group
   localparam logic [3:0] DIGITS_LONG  = 4'd8;
   localparam logic [3:0] DIGITS_SHORT = 4'd4;

   // Top bits of a UTF-16 unit that mark high and low surrogates
   localparam logic [5:0] SURR_HI_TAG = 6'b110110;
   localparam logic [5:0] SURR_LO_TAG = 6'b110111;
   localparam logic [20:0] PAIR_BIAS  = 21'h10000;

   // Queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Item kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [3:0] {
      ST_OK      = 4'd0,
      ST_TRUNC   = 4'd1,
      ST_NO_BS   = 4'd2,
      ST_NO_U    = 4'd3,
      ST_BAD_HEX = 4'd4,
      ST_LONE_LO = 4'd5,
      ST_NO_BS2  = 4'd6,
      ST_NO_U2   = 4'd7,
      ST_NOT_LO2 = 4'd8
   } status_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [31:0] code_point;
      logic [3:0]  consumed;
      status_type  status;
   } rsp_type;

   // One character after classification
   typedef struct packed {
      logic       is_end;
      logic       is_bs;
      logic       is_lower_u;
      logic       is_upper_u;
      logic       hex_ok;
      logic [3:0] nibble;
   } class_type;

endpackage : uep_pkg
`default_nettype wire

FILE: hw/rtl/unicode_escape_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_escape_parser_unit
// Decodes one \uXXXX, \uXXXX\uXXXX surrogate pair or \UXXXXXXXX escape per
// sequence from a character stream and reports code point, length and status.
// ----------------------------------------------------------------------------
// The unit takes one character beat per clock and never stalls on its own:
// req_full rises only when the response beat is left unpopped long enough for
// the four-entry character queue to fill. The back-end state machine handles
// each character in a single update, which sets the rate. A response appears
// on rsp_data once the beat ending the sequence has passed through the queue
// and the state machine has taken it and loaded the response register; that
// take waits while an unpopped response still holds the register. Exactly one
// response comes per sequence, on success or at the
// first error; an end-of-text beat always yields a truncated response, even
// when no sequence has started, and the parser then returns to idle.
// ----------------------------------------------------------------------------
module unicode_escape_parser_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   output logic                  req_full,
   input  wire uep_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output uep_pkg::rsp_type      rsp_data
);

   uep_pkg::class_type front_class;
   uep_pkg::class_type queue_head;
   logic               queue_empty;
   logic               back_take;
   logic               back_rsp_valid;

   // Front: classify the character as it arrives
   uep_front u_front (
      .req_data   (req_data),
      .class_data (front_class)
   );

   // Decouple the input side from the state machine
   uep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_class),
      .full      (req_full),
      .pop       (back_take),
      .empty     (queue_empty),
      .pop_data  (queue_head)
   );

   // Back: advance the parser one character per cycle while the response slot is
   // free or drains; it stalls while the last result waits unpopped
   uep_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!queue_empty),
      .item       (queue_head),
      .item_take  (back_take),
      .rsp_valid  (back_rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_pop    (rsp_pop)
   );

   assign rsp_empty = !back_rsp_valid;

endmodule : unicode_escape_parser_unit
`default_nettype wire

FILE: hw/rtl/uep_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uep_front
// Classifies each incoming character: end of text, backslash, u, U, and the
// hex digit value where it is one.
// ----------------------------------------------------------------------------
module uep_front (
   input  wire uep_pkg::req_type   req_data,
   output uep_pkg::class_type      class_data
);

   logic [7:0] c;

   assign c = req_data.char_code;

   always_comb begin
      class_data            = '0;
      class_data.is_end     = (req_data.kind == uep_pkg::KIND_END);
      class_data.is_bs      = (c == uep_pkg::CHAR_BACKSLASH);
      class_data.is_lower_u = (c == uep_pkg::CHAR_LOWER_U);
      class_data.is_upper_u = (c == uep_pkg::CHAR_UPPER_U);
      if (c >= 8'h30 && c <= 8'h39) begin
         class_data.hex_ok = 1'b1;
         class_data.nibble = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         // A-F and a-f share the low three bits: value is 9 + low bits
         class_data.hex_ok = 1'b1;
         class_data.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
      end
   end

endmodule : uep_front
`default_nettype wire

FILE: hw/rtl/uep_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uep_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module uep_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire uep_pkg::class_type push_data,
   output logic                    full,
   input  wire                     pop,
   output logic                    empty,
   output uep_pkg::class_type      pop_data
);

   uep_pkg::class_type             mem_ff [uep_pkg::QUEUE_DEPTH];
   logic [uep_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [uep_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [uep_pkg::QUEUE_AW:0]     count_ff, count_in;
   logic                           do_wr, do_rd;

   assign full     = (count_ff == (uep_pkg::QUEUE_AW+1)'(uep_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_wr    = push && !full;
   assign do_rd    = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule : uep_queue
`default_nettype wire

FILE: hw/rtl/uep_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uep_back
// Escape sequence state machine. Takes one classified character per cycle while
// the response slot is free or drains, and loads it on completion or first error.
// ----------------------------------------------------------------------------
module uep_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     item_valid,
   input  wire uep_pkg::class_type item,
   output logic                    item_take,
   output logic                    rsp_valid,
   output uep_pkg::rsp_type        rsp_data,
   input  wire                     rsp_pop
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_KIND,
      PH_HEX32,
      PH_HEX16A,
      PH_BS2,
      PH_U2,
      PH_HEX16B
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [3:0]         digit_ff, digit_in;
   logic [31:0]        acc_ff, acc_in;
   logic [9:0]         first_ff, first_in;
   logic [3:0]         count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   uep_pkg::rsp_type   rsp_ff, rsp_in;

   logic               fin;
   uep_pkg::rsp_type   fin_rsp;
   logic [3:0]         used;
   logic [31:0]        acc_next;
   logic [3:0]         digit_next;
   logic [20:0]        pair_cp;

   // Advance when the response slot is free or drains this cycle
   assign item_take  = item_valid && (!rsp_valid_ff || rsp_pop);
   assign used       = count_ff + 4'd1;
   assign acc_next   = {acc_ff[27:0], item.nibble};
   assign digit_next = digit_ff + 4'd1;
   assign pair_cp    = {1'b0, first_ff, acc_next[9:0]} + uep_pkg::PAIR_BIAS;

   always_comb begin
      phase_in = phase_ff;
      digit_in = digit_ff;
      acc_in   = acc_ff;
      first_in = first_ff;
      count_in = used;
      fin      = 1'b0;
      fin_rsp  = '{code_point: 32'd0, consumed: used, status: uep_pkg::ST_OK};

      if (item.is_end) begin
         fin             = 1'b1;
         fin_rsp.consumed = count_ff;
         fin_rsp.status  = uep_pkg::ST_TRUNC;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (item.is_bs) begin
                  phase_in = PH_KIND;
               end else begin
                  fin            = 1'b1;
                  fin_rsp.status = uep_pkg::ST_NO_BS;
               end
            end
            PH_KIND: begin
               digit_in = '0;
               acc_in   = '0;
               if (item.is_upper_u) begin
                  phase_in = PH_HEX32;
               end else if (item.is_lower_u) begin
                  phase_in = PH_HEX16A;
               end else begin
                  fin            = 1'b1;
                  fin_rsp.status = uep_pkg::ST_NO_U;
               end
            end
            PH_HEX32, PH_HEX16A, PH_HEX16B: begin
               acc_in   = acc_next;
               digit_in = digit_next;
               if (!item.hex_ok) begin
                  fin            = 1'b1;
                  fin_rsp.status = uep_pkg::ST_BAD_HEX;
               end else if (phase_ff == PH_HEX32) begin
                  if (digit_next == uep_pkg::DIGITS_LONG) begin
                     fin                = 1'b1;
                     fin_rsp.code_point = acc_next;
                  end
               end else if (digit_next == uep_pkg::DIGITS_SHORT) begin
                  fin = 1'b1;
                  if (phase_ff == PH_HEX16A) begin
                     if (acc_next[15:10] == uep_pkg::SURR_LO_TAG) begin
                        fin_rsp.status = uep_pkg::ST_LONE_LO;
                     end else if (acc_next[15:10] == uep_pkg::SURR_HI_TAG) begin
                        // Hold the high half and wait for the second escape
                        fin      = 1'b0;
                        first_in = acc_next[9:0];
                        phase_in = PH_BS2;
                     end else begin
                        fin_rsp.code_point = {16'd0, acc_next[15:0]};
                     end
                  end else if (acc_next[15:10] != uep_pkg::SURR_LO_TAG) begin
                     fin_rsp.status = uep_pkg::ST_NOT_LO2;
                  end else begin
                     fin_rsp.code_point = {11'd0, pair_cp};
                  end
               end
            end
            PH_BS2: begin
               if (item.is_bs) begin
                  phase_in = PH_U2;
               end else begin
                  fin            = 1'b1;
                  fin_rsp.status = uep_pkg::ST_NO_BS2;
               end
            end
            PH_U2: begin
               digit_in = '0;
               acc_in   = '0;
               if (item.is_lower_u) begin
                  phase_in = PH_HEX16B;
               end else begin
                  fin            = 1'b1;
                  fin_rsp.status = uep_pkg::ST_NO_U2;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // Drop all sequence state once a result is out
      if (fin) begin
         phase_in = PH_IDLE;
         digit_in = '0;
         acc_in   = '0;
         first_in = '0;
         count_in = '0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      if (item_take && fin) begin
         rsp_valid_in = 1'b1;
         rsp_in       = fin_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         digit_ff     <= '0;
         acc_ff       <= '0;
         first_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_take) begin
            phase_ff <= phase_in;
            digit_ff <= digit_in;
            acc_ff   <= acc_in;
            first_ff <= first_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : uep_back
`default_nettype wire

FILE: hw/rtl/unicode_escape_parser_unit_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_escape_parser_unit_checker
// Port-level checks on the parser, bound to the top level.
// ----------------------------------------------------------------------------
module unicode_escape_parser_unit_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_full,
   input wire                   rsp_empty,
   input wire                   rsp_pop,
   input wire uep_pkg::rsp_type rsp_data
);

   // Reset drains both sides
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue or response not cleared by reset");

   // A waiting response holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("response changed while waiting");

   // Error responses carry no code point
   a_err_zero_cp: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != uep_pkg::ST_OK) |-> (rsp_data.code_point == 32'd0))
      else $error("nonzero code point on error");

   // Successful sequences are 6, 10 or 12 characters long
   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == uep_pkg::ST_OK) |->
         (rsp_data.consumed == 4'd6 || rsp_data.consumed == 4'd10 ||
          rsp_data.consumed == 4'd12))
      else $error("bad length on successful response");

   // A surrogate pair always lands in the supplementary planes
   a_pair_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == uep_pkg::ST_OK && rsp_data.consumed == 4'd12) |->
         (rsp_data.code_point >= 32'h10000 && rsp_data.code_point <= 32'h10FFFF))
      else $error("surrogate pair out of range");

endmodule : unicode_escape_parser_unit_checker

bind unicode_escape_parser_unit unicode_escape_parser_unit_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for unicode_escape_parser_unit. A queue of character
// beats feeds a clocked driver. A built-in decoder predicts every response
// as each beat is accepted. A clocked monitor pops responses and compares
// them with the oldest prediction. Stimulus is a short directed run, then
// random escape sequences: well-formed ones, broken ones and noise. These
// run under four idle and stall profiles on the two channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import uep_pkg::*;

   // ASCII bounds of the hex digit ranges, and a stand-in lower-case x
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   localparam int PHASE_BEATS = 150;

   // Decoder states of the predictor
   typedef enum logic [2:0] {
      DP_IDLE,
      DP_KIND,
      DP_HEX32,
      DP_HEX16A,
      DP_BS2,
      DP_U2,
      DP_HEX16B
   } decode_phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   // Character beats waiting to be driven, and responses the decoder owes
   req_type     char_backlog[$];
   rsp_type     decoded_due[$];
   logic [7:0]  pending_chars[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int fail_count         = 0;

   // Predictor state
   decode_phase_type dec_phase     = DP_IDLE;
   logic [3:0]       dec_digits    = '0;
   logic [31:0]      dec_acc       = '0;
   logic [15:0]      dec_high_unit = '0;
   logic [3:0]       dec_count     = '0;

   unicode_escape_parser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic void clear_decoder();
      dec_phase     = DP_IDLE;
      dec_digits    = '0;
      dec_acc       = '0;
      dec_high_unit = '0;
      dec_count     = '0;
   endfunction

   // Advance the predictor by one accepted beat; done marks a response.
   task automatic predict_decode(input req_type beat, output bit done, output rsp_type res);
      logic [7:0]  c;
      logic [3:0]  used;
      logic [4:0]  nib;
      logic [31:0] value;
      status_type  st;
      c     = beat.char_code;
      used  = dec_count;
      nib   = 5'h10;   // top bit set: not a hex digit
      value = '0;
      st    = ST_OK;
      done  = 1'b0;
      res   = '0;
      if (beat.kind == KIND_END) begin
         // end of text always closes out, whatever the phase
         done = 1'b1;
         st   = ST_TRUNC;
      end else begin
         used      = dec_count + 4'd1;
         dec_count = used;
         case (dec_phase)
            DP_IDLE: begin
               if (c == CHAR_BACKSLASH) dec_phase = DP_KIND;
               else begin
                  done = 1'b1;
                  st   = ST_NO_BS;
               end
            end
            DP_KIND: begin
               dec_digits = '0;
               dec_acc    = '0;
               if (c == CHAR_UPPER_U) dec_phase = DP_HEX32;
               else if (c == CHAR_LOWER_U) dec_phase = DP_HEX16A;
               else begin
                  done = 1'b1;
                  st   = ST_NO_U;
               end
            end
            DP_BS2: begin
               if (c == CHAR_BACKSLASH) dec_phase = DP_U2;
               else begin
                  done = 1'b1;
                  st   = ST_NO_BS2;
               end
            end
            DP_U2: begin
               if (c == CHAR_LOWER_U) begin
                  dec_phase  = DP_HEX16B;
                  dec_digits = '0;
                  dec_acc    = '0;
               end else begin
                  done = 1'b1;
                  st   = ST_NO_U2;
               end
            end
            default: begin
               // one of the three hex groups
               if (c >= CH_ZERO && c <= CH_NINE) nib = {1'b0, 4'(c - CH_ZERO)};
               else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
                  nib = {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
               else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
                  nib = {1'b0, 4'(c - CH_LOWER_A + 8'd10)};
               if (nib[4]) begin
                  done = 1'b1;
                  st   = ST_BAD_HEX;
               end else begin
                  dec_acc    = {dec_acc[27:0], nib[3:0]};
                  dec_digits = dec_digits + 4'd1;
                  if (dec_phase == DP_HEX32) begin
                     // long form is taken as is, no range check
                     if (dec_digits == DIGITS_LONG) begin
                        done  = 1'b1;
                        value = dec_acc;
                     end
                  end else if (dec_digits == DIGITS_SHORT) begin
                     dec_acc = {16'h0, dec_acc[15:0]};
                     if (dec_phase == DP_HEX16A) begin
                        if (dec_acc[15:10] == SURR_LO_TAG) begin
                           done = 1'b1;
                           st   = ST_LONE_LO;
                        end else if (dec_acc[15:10] == SURR_HI_TAG) begin
                           dec_high_unit = dec_acc[15:0];
                           dec_phase     = DP_BS2;
                        end else begin
                           done  = 1'b1;
                           value = dec_acc;
                        end
                     end else if (dec_acc[15:10] != SURR_LO_TAG) begin
                        done = 1'b1;
                        st   = ST_NOT_LO2;
                     end else begin
                        done  = 1'b1;
                        value = 32'(PAIR_BIAS) + {12'h0, dec_high_unit[9:0], dec_acc[9:0]};
                     end
                  end
               end
            end
         endcase
      end
      if (done) begin
         res.code_point = (st == ST_OK) ? value : '0;
         res.consumed   = used;
         res.status     = st;
         clear_decoder();
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders: collect characters in pending_chars, then move
   // them to the beat backlog in one go.
   // ------------------------------------------------------------------
   task automatic add_hex(input logic [31:0] v, input int digits);
      logic [3:0] nib;
      for (int i = digits - 1; i >= 0; i--) begin
         nib = v[4*i +: 4];
         if (nib < 4'd10) pending_chars.push_back(CH_ZERO + 8'(nib));
         else if ($urandom_range(0, 1) == 1)
            pending_chars.push_back(CH_UPPER_A + 8'(nib) - 8'd10);
         else
            pending_chars.push_back(CH_LOWER_A + 8'(nib) - 8'd10);
      end
   endtask

   task automatic add_unit(input logic [15:0] unit);
      pending_chars.push_back(CHAR_BACKSLASH);
      pending_chars.push_back(CHAR_LOWER_U);
      add_hex({16'h0, unit}, 4);
   endtask

   task automatic add_long(input logic [31:0] v);
      pending_chars.push_back(CHAR_BACKSLASH);
      pending_chars.push_back(CHAR_UPPER_U);
      add_hex(v, 8);
   endtask

   task automatic send_chars();
      req_type beat;
      foreach (pending_chars[i]) begin
         beat.kind      = KIND_CHAR;
         beat.char_code = pending_chars[i];
         char_backlog.push_back(beat);
      end
      pending_chars.delete();
   endtask

   task automatic send_end();
      req_type beat;
      beat.kind      = KIND_END;
      beat.char_code = 8'($urandom);   // ignored by the block, so randomize it
      char_backlog.push_back(beat);
   endtask

   function automatic logic [15:0] plain_unit();
      logic [15:0] u;
      case ($urandom_range(0, 5))
         0:       u = 16'h0000;
         1:       u = 16'hFFFF;
         default: u = 16'($urandom);
      endcase
      // flip out of the surrogate block to keep the unit plain
      if (u[15:11] == 5'b11011) u = u ^ 16'h4000;
      return u;
   endfunction

   function automatic logic [15:0] high_unit();
      return 16'hD800 | 16'($urandom_range(0, 1023));
   endfunction

   function automatic logic [15:0] low_unit();
      return 16'hDC00 | 16'($urandom_range(0, 1023));
   endfunction

   task automatic add_valid();
      logic [31:0] wide;
      case ($urandom_range(0, 2))
         0: add_unit(plain_unit());
         1: begin
            case ($urandom_range(0, 3))
               0:       wide = 32'h0000_0000;
               1:       wide = 32'hFFFF_FFFF;
               2:       wide = {16'h0, low_unit()};   // surrogate value passes in long form
               default: wide = $urandom;
            endcase
            add_long(wide);
         end
         default: begin
            add_unit(high_unit());
            add_unit(low_unit());
         end
      endcase
   endtask

   task automatic random_sequence();
      int          pick;
      int          cut;
      logic [7:0]  c;
      logic [15:0] u;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         add_valid();
         send_chars();
      end else if (pick < 52) begin
         add_unit(low_unit());
         send_chars();
      end else if (pick < 65) begin
         // good high surrogate, then a second escape that goes wrong
         add_unit(high_unit());
         case ($urandom_range(0, 2))
            0: begin
               c = 8'($urandom);
               if (c == CHAR_BACKSLASH) c = CH_LOWER_X;
               pending_chars.push_back(c);
            end
            1: begin
               pending_chars.push_back(CHAR_BACKSLASH);
               c = ($urandom_range(0, 1) == 1) ? CHAR_UPPER_U : 8'($urandom);
               if (c == CHAR_LOWER_U) c = CH_LOWER_X;
               pending_chars.push_back(c);
            end
            default: begin
               u = ($urandom_range(0, 1) == 1) ? high_unit() : plain_unit();
               add_unit(u);
            end
         endcase
         send_chars();
      end else if (pick < 85) begin
         // cut a valid sequence short: end of text or a stray character
         add_valid();
         cut = $urandom_range(1, pending_chars.size() - 1);
         while (pending_chars.size() > cut) void'(pending_chars.pop_back());
         if ($urandom_range(0, 1) == 1) begin
            send_chars();
            send_end();
         end else begin
            pending_chars.push_back(8'($urandom));
            send_chars();
         end
      end else if ($urandom_range(0, 3) == 0) begin
         send_end();
      end else begin
         pending_chars.push_back(8'($urandom));
         send_chars();
      end
   endtask

   // Hold until every beat is taken and every response has been checked.
   task automatic drain();
      while (char_backlog.size() != 0 || decoded_due.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: offer the head of the backlog, hold it while the block is
   // full, and predict each beat at the edge that accepts it.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_chars
      bit      taken;
      bit      got;
      rsp_type res;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         taken = req_push && !req_full;
         if (taken) begin
            predict_decode(req_data, got, res);
            if (got) decoded_due.push_back(res);
            void'(char_backlog.pop_front());
         end
         if (req_push && !taken) begin
            // hold the beat as is until the block takes it
         end else if (char_backlog.size() != 0 &&
                      $urandom_range(0, 99) >= sender_idle_pct) begin
            req_push <= 1'b1;
            req_data <= char_backlog[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each popped response against the oldest prediction,
   // then decide whether to stall the next cycle.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (decoded_due.size() == 0) begin
               $error("response with none expected: code_point %h consumed %0d status %0d",
                      rsp_data.code_point, rsp_data.consumed, rsp_data.status);
               fail_count++;
            end else begin
               want = decoded_due.pop_front();
               if (rsp_data.code_point !== want.code_point) begin
                  $error("code_point: expected %h, got %h", want.code_point,
                         rsp_data.code_point);
                  fail_count++;
               end
               if (rsp_data.consumed !== want.consumed) begin
                  $error("consumed: expected %0d, got %0d", want.consumed,
                         rsp_data.consumed);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: reset, directed beats, then four random phases with
   // different idle and stall profiles. Each phase boundary drains the
   // block completely, so the sender pauses until nothing is owed.
   // ------------------------------------------------------------------
   initial begin : stimulus
      int sender_plan[4];
      int receiver_plan[4];
      sender_plan   = '{0, 58, 0, 34};
      receiver_plan = '{0, 0, 58, 34};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // end of text with nothing started
      send_end();
      // end of text part way through a short escape
      pending_chars.push_back(CHAR_BACKSLASH);
      pending_chars.push_back(CHAR_LOWER_U);
      pending_chars.push_back(CH_ZERO + 8'd1);
      send_chars();
      send_end();
      // extreme characters where a backslash belongs
      pending_chars.push_back(8'hFF);
      pending_chars.push_back(8'h00);
      // lone low surrogate, then a high surrogate with a bad second unit
      add_unit(16'hDFFF);
      add_unit(16'hDBFF);
      add_unit(16'hE000);
      send_chars();

      for (int p = 0; p < 4; p++) begin
         drain();
         sender_idle_pct    = sender_plan[p];
         receiver_stall_pct = receiver_plan[p];
         while (char_backlog.size() < PHASE_BEATS) random_sequence();
      end
      // flush any half-built sequence so the parser ends idle
      send_end();
      drain();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of ~650 beats
   initial begin : watchdog
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule : testbench
